[src/cda_pkg.sv]
// Shared types, constants and calendar functions for the date advance block.
// Used by cda_ctrl, cda_datapath and calendar_date_advance.
// Has no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cda_pkg;

	// Width of the internal year register.
	localparam int YEAR_BITS = 16;
	localparam logic [YEAR_BITS-1:0] YEAR_MAX = '1;

	// Widths of the request and result fields.
	localparam int DAY_BITS = 5;
	localparam int MONTH_BITS = 4;
	localparam int LOAD_YEAR_BITS = 16;
	localparam int COUNT_BITS = 16;
	localparam int OUT_YEAR_BITS = 16;

	// The running day sum holds a day of up to 31 plus a full count.
	localparam int SUM_BITS = COUNT_BITS + 1;

	// Calendar constants.
	localparam logic [MONTH_BITS-1:0] MONTHS_PER_YEAR = MONTH_BITS'(12);
	localparam logic [MONTH_BITS-1:0] FEBRUARY = MONTH_BITS'(1);
	localparam logic [MONTH_BITS-1:0] DECEMBER = MONTH_BITS'(11);

	// Year modulo 400 is kept in a 9-bit register for the leap test.
	localparam int REM_BITS = 9;
	localparam logic [REM_BITS-1:0] CYCLE_LAST = REM_BITS'(399);
	localparam logic [REM_BITS-1:0] CENTURY_1 = REM_BITS'(100);
	localparam logic [REM_BITS-1:0] CENTURY_2 = REM_BITS'(200);
	localparam logic [REM_BITS-1:0] CENTURY_3 = REM_BITS'(300);

	// Year modulo 400: the year is 16 * hi + lo and 400 is 16 * 25, so only hi
	// is divided by 25, through a multiply by a rounded-up reciprocal.
	localparam int YMOD_LO_BITS = 4;
	localparam int YMOD_HI_BITS = YEAR_BITS - YMOD_LO_BITS;
	localparam int YMOD_Q_BITS = YMOD_HI_BITS - 4;
	localparam int YMOD_SHIFT = 33;
	localparam int YMOD_MULT_BITS = 29;
	localparam int YMOD_PROD_BITS = YMOD_HI_BITS + YMOD_MULT_BITS;
	localparam logic [4:0] YMOD_DIV = 5'd25;
	localparam logic [YMOD_MULT_BITS-1:0] YMOD_MULT = YMOD_MULT_BITS'(
		((64'd1 << YMOD_SHIFT) + 64'(YMOD_DIV) - 64'd1) / 64'(YMOD_DIV));

	// Count modulo 12: the count is 4 * hi + lo and 12 is 4 * 3, so only hi is
	// divided by 3, again through a reciprocal multiply.
	localparam int CMOD_LO_BITS = 2;
	localparam int CMOD_HI_BITS = COUNT_BITS - CMOD_LO_BITS;
	localparam int CMOD_Q_BITS = CMOD_HI_BITS - 1;
	localparam int CMOD_SHIFT = COUNT_BITS;
	localparam int CMOD_MULT_BITS = COUNT_BITS - 1;
	localparam int CMOD_PROD_BITS = CMOD_HI_BITS + CMOD_MULT_BITS;
	localparam logic [1:0] CMOD_DIV = 2'd3;
	localparam logic [CMOD_MULT_BITS-1:0] CMOD_MULT = CMOD_MULT_BITS'(
		((64'd1 << CMOD_SHIFT) + 64'(CMOD_DIV) - 64'd1) / 64'(CMOD_DIV));

	// Command codes.
	typedef enum logic [1:0] {
		CMD_LOAD       = 2'd0,
		CMD_ADD_DAYS   = 2'd1,
		CMD_ADD_MONTHS = 2'd2
	} cmd_t;

	// Controller states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_REM,
		S_LOAD_FIN,
		S_MON_FIN,
		S_WALK,
		S_POST
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic rem_step;
		logic load_fin;
		logic mon_fin;
		logic walk;
		logic post;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic rem_for_year;
		logic walk_done;
	} dp_sts_t;

	// Gregorian leap test from the year taken modulo 400.
	function automatic logic leap_from_mod400(input logic [REM_BITS-1:0] ym);
		return (ym[1:0] == 2'b00) && (ym != CENTURY_1) && (ym != CENTURY_2) &&
			(ym != CENTURY_3);
	endfunction

	// Length of a month in days.
	function automatic logic [DAY_BITS-1:0] month_length(input logic [MONTH_BITS-1:0] m,
			input logic leap);
		logic [DAY_BITS-1:0] len;
		unique case (m)
			4'd1:    len = leap ? DAY_BITS'(29) : DAY_BITS'(28);
			4'd3, 4'd5, 4'd8, 4'd10: len = DAY_BITS'(30);
			default: len = DAY_BITS'(31);
		endcase
		return len;
	endfunction

endpackage

`default_nettype wire

[src/cda_datapath.sv]
// Datapath of the date advance block: date registers, reciprocal remainder unit,
// month walker and result registers.
// Depends on cda_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cda_datapath (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire cda_pkg::dp_cmd_t                cmd,
	output cda_pkg::dp_sts_t                     sts,
	input  wire logic [1:0]                      command,
	input  wire logic [cda_pkg::DAY_BITS-1:0]    load_day,
	input  wire logic [cda_pkg::MONTH_BITS-1:0]  load_month,
	input  wire logic [cda_pkg::LOAD_YEAR_BITS-1:0] load_year,
	input  wire logic [cda_pkg::COUNT_BITS-1:0]  count,
	output logic [cda_pkg::DAY_BITS-1:0]         day,
	output logic [cda_pkg::MONTH_BITS-1:0]       month,
	output logic [cda_pkg::OUT_YEAR_BITS-1:0]    year,
	output logic                                 year_overflow
);
	import cda_pkg::*;

	// Current date and the year modulo 400 kept alongside it.
	logic [DAY_BITS-1:0]   day_q;
	logic [MONTH_BITS-1:0] month_q;
	logic [YEAR_BITS-1:0]  year_q;
	logic [REM_BITS-1:0]   ymod_q;
	logic                  ovf_q;

	// Captured request fields.
	logic [DAY_BITS-1:0]   ld_day_q;
	logic [MONTH_BITS-1:0] ld_month_q;
	logic [YEAR_BITS-1:0]  ld_year_q;
	logic [COUNT_BITS-1:0] cnt_q;
	logic                  sel_year_q;

	// Registered quotients and the day sum.
	logic [YMOD_Q_BITS-1:0] year_quo_q;
	logic [CMOD_Q_BITS-1:0] cnt_quo_q;
	logic [SUM_BITS-1:0]    sum_q;

	// Result registers.
	logic [DAY_BITS-1:0]   day_out_q;
	logic [MONTH_BITS-1:0] month_out_q;
	logic [YEAR_BITS-1:0]  year_out_q;
	logic                  ovf_out_q;

	logic [YMOD_PROD_BITS-1:0] ymod_prod;
	logic [CMOD_PROD_BITS-1:0] cmod_prod;
	logic [YMOD_HI_BITS-1:0]   ymod_hi;
	logic [CMOD_HI_BITS-1:0]   cmod_hi;
	logic [REM_BITS-1:0]       ld_ymod;
	logic [MONTH_BITS-1:0]     cnt_mod;
	logic [DAY_BITS-1:0]       cur_len;
	logic                      walk_more;
	logic [MONTH_BITS-1:0]     ld_month_red;
	logic [DAY_BITS-1:0]       ld_len;
	logic [DAY_BITS-1:0]       ld_day_fix;
	logic [MONTH_BITS:0]       mon_sum;
	logic [MONTH_BITS:0]       mon_wrap;

	// Quotients by reciprocal multiplication: the year's upper bits by 25 and the
	// count's upper bits by 3.
	assign ymod_prod = YMOD_PROD_BITS'(ld_year_q[YEAR_BITS-1:YMOD_LO_BITS]) *
		YMOD_PROD_BITS'(YMOD_MULT);
	assign cmod_prod = CMOD_PROD_BITS'(cnt_q[COUNT_BITS-1:CMOD_LO_BITS]) *
		CMOD_PROD_BITS'(CMOD_MULT);

	// Remainders from the registered quotients: year modulo 400 and count modulo 12.
	always_comb begin
		ymod_hi = ld_year_q[YEAR_BITS-1:YMOD_LO_BITS] -
			YMOD_HI_BITS'(year_quo_q) * YMOD_HI_BITS'(YMOD_DIV);
		cmod_hi = cnt_q[COUNT_BITS-1:CMOD_LO_BITS] -
			CMOD_HI_BITS'(cnt_quo_q) * CMOD_HI_BITS'(CMOD_DIV);
		ld_ymod = {ymod_hi[4:0], ld_year_q[YMOD_LO_BITS-1:0]};
		cnt_mod = {cmod_hi[1:0], cnt_q[CMOD_LO_BITS-1:0]};
	end

	// Month walk: compare the running sum with the current month length.
	assign cur_len = month_length(month_q, leap_from_mod400(ymod_q));
	assign walk_more = sum_q > SUM_BITS'(cur_len);

	// Load: reduce the month and clamp the day into the loaded month.
	always_comb begin
		ld_month_red = (ld_month_q >= MONTHS_PER_YEAR) ? ld_month_q - MONTHS_PER_YEAR
			: ld_month_q;
		ld_len = month_length(ld_month_red, leap_from_mod400(ld_ymod));
		if (ld_day_q == '0) begin
			ld_day_fix = DAY_BITS'(1);
		end else if (ld_day_q > ld_len) begin
			ld_day_fix = ld_len;
		end else begin
			ld_day_fix = ld_day_q;
		end
	end

	// Add-months: the remainder of the count is below twelve.
	always_comb begin
		mon_sum = {1'b0, month_q} + {1'b0, cnt_mod};
		mon_wrap = (mon_sum >= {1'b0, MONTHS_PER_YEAR}) ? mon_sum - {1'b0, MONTHS_PER_YEAR}
			: mon_sum;
	end

	// Date state, cleared to the first of January of year zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			day_q <= DAY_BITS'(1);
			month_q <= '0;
			year_q <= '0;
			ymod_q <= '0;
			ovf_q <= 1'b0;
		end else begin
			if (cmd.capture) begin
				ovf_q <= 1'b0;
			end
			if (cmd.load_fin) begin
				day_q <= ld_day_fix;
				month_q <= ld_month_red;
				year_q <= ld_year_q;
				ymod_q <= ld_ymod;
			end
			if (cmd.mon_fin) begin
				month_q <= MONTH_BITS'(mon_wrap);
			end
			if (cmd.walk) begin
				if (walk_more) begin
					if (month_q == DECEMBER) begin
						month_q <= '0;
						if (year_q == YEAR_MAX) begin
							ovf_q <= 1'b1;
						end else begin
							year_q <= year_q + YEAR_BITS'(1);
							ymod_q <= (ymod_q == CYCLE_LAST) ? '0 : ymod_q + REM_BITS'(1);
						end
					end else begin
						month_q <= month_q + MONTH_BITS'(1);
					end
				end else begin
					day_q <= DAY_BITS'(sum_q);
				end
			end
		end
	end

	// Request capture, quotient registers and day sum.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			ld_day_q <= load_day;
			ld_month_q <= load_month;
			ld_year_q <= YEAR_BITS'(load_year);
			cnt_q <= count;
			sel_year_q <= (command == CMD_LOAD);
			sum_q <= SUM_BITS'(day_q) + SUM_BITS'(count);
		end
		if (cmd.rem_step) begin
			year_quo_q <= ymod_prod[YMOD_PROD_BITS-1:YMOD_SHIFT];
			cnt_quo_q <= cmod_prod[CMOD_PROD_BITS-1:CMOD_SHIFT];
		end
		if (cmd.walk && walk_more) begin
			sum_q <= sum_q - SUM_BITS'(cur_len);
		end
	end

	// Result registers hold the posted date until it is taken.
	always_ff @(posedge clk) begin
		if (cmd.post) begin
			day_out_q <= day_q;
			month_out_q <= month_q;
			year_out_q <= year_q;
			ovf_out_q <= ovf_q;
		end
	end

	assign sts.rem_for_year = sel_year_q;
	assign sts.walk_done = !walk_more;

	assign day = day_out_q;
	assign month = month_out_q;
	assign year = OUT_YEAR_BITS'(year_out_q);
	assign year_overflow = ovf_out_q;

endmodule

`default_nettype wire

[src/cda_ctrl.sv]
// Controller of the date advance block: sequences capture, remainder steps,
// month walk and result posting, and owns the handshakes.
// Depends on cda_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cda_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire logic [1:0]       command,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output cda_pkg::dp_cmd_t      cmd,
	input  wire cda_pkg::dp_sts_t sts
);
	import cda_pkg::*;

	state_t state_q;
	state_t state_nxt;
	logic   out_valid_q;

	// State and result valid registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.post) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Next state and datapath commands.
	always_comb begin
		state_nxt = state_q;
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					unique case (command)
						CMD_LOAD, CMD_ADD_MONTHS: state_nxt = S_REM;
						CMD_ADD_DAYS:             state_nxt = S_WALK;
						default:                  state_nxt = S_POST;
					endcase
				end
			end
			S_REM: begin
				cmd.rem_step = 1'b1;
				state_nxt = sts.rem_for_year ? S_LOAD_FIN : S_MON_FIN;
			end
			S_LOAD_FIN: begin
				cmd.load_fin = 1'b1;
				state_nxt = S_POST;
			end
			S_MON_FIN: begin
				cmd.mon_fin = 1'b1;
				state_nxt = S_POST;
			end
			S_WALK: begin
				cmd.walk = 1'b1;
				if (sts.walk_done) begin
					state_nxt = S_POST;
				end
			end
			S_POST: begin
				if (!out_valid_q || !out_stall) begin
					cmd.post = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	assign in_stall = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

[src/calendar_date_advance.sv]
// Calendar date register. Load and add-months pass through a remainder step (S_REM) and
// a finish step before posting; an unused command goes straight to posting; add-days walks.
// Load and add-months register a reciprocal-multiply quotient, then form the remainder;
// add-days is bounded by the month walker, which crosses one month per cycle.
// One request is in work at a time; posting waits while an earlier result is stalled.
// Reset (arst_n low, asynchronous) sets the date to day 1, January, year 0.
`timescale 1ns / 1ps
`default_nettype none

module calendar_date_advance (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic [1:0]                      command,
	input  wire logic [cda_pkg::DAY_BITS-1:0]    load_day,
	input  wire logic [cda_pkg::MONTH_BITS-1:0]  load_month,
	input  wire logic [cda_pkg::LOAD_YEAR_BITS-1:0] load_year,
	input  wire logic [cda_pkg::COUNT_BITS-1:0]  count,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic [cda_pkg::DAY_BITS-1:0]         day,
	output logic [cda_pkg::MONTH_BITS-1:0]       month,
	output logic [cda_pkg::OUT_YEAR_BITS-1:0]    year,
	output logic                                 year_overflow
);
	import cda_pkg::*;

	dp_cmd_t dp_cmd;
	dp_sts_t dp_sts;

	// Controller.
	cda_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.command   (command),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (dp_cmd),
		.sts       (dp_sts)
	);

	// Datapath.
	cda_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (dp_cmd),
		.sts           (dp_sts),
		.command       (command),
		.load_day      (load_day),
		.load_month    (load_month),
		.load_year     (load_year),
		.count         (count),
		.day           (day),
		.month         (month),
		.year          (year),
		.year_overflow (year_overflow)
	);

	// A request that is taken leaves the input side busy in the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken again right after a request");

	// A saturated result always carries the largest year.
	a_ovf_year: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && year_overflow) |-> (year == OUT_YEAR_BITS'(YEAR_MAX)))
		else $error("overflow flag without saturated year");

	// A posted month is always reduced.
	a_month_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (month < MONTHS_PER_YEAR))
		else $error("result month out of range");

	// A posted day is never zero.
	a_day_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (day != '0))
		else $error("result day is zero");

endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
// Self-checking testbench for calendar_date_advance: directed date cases, then random traffic.
// A local calendar predictor is compared against every result; depends on cda_pkg and the RTL.
`timescale 1ns / 1ps

module tb_top;
	import cda_pkg::*;

	// Command value that has no operation behind it.
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int CLK_HALF = 6;
	localparam int RESET_CYCLES = 7;
	// Sized for about 280 requests at the longest add-days walk, doubled by stalls.
	localparam int LIMIT_CYCLES = 6_000_000;
	localparam int DRAIN_CYCLES = 40;
	localparam int MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

	typedef struct packed {
		logic [DAY_BITS-1:0]      day;
		logic [MONTH_BITS-1:0]    month;
		logic [OUT_YEAR_BITS-1:0] year;
		logic                     ovf;
	} date_result_t;

	logic                      clk;
	logic                      arst_n = 1'b0;
	logic                      in_valid = 1'b0;
	logic                      in_stall;
	logic [1:0]                command = CMD_LOAD;
	logic [DAY_BITS-1:0]       load_day = '0;
	logic [MONTH_BITS-1:0]     load_month = '0;
	logic [LOAD_YEAR_BITS-1:0] load_year = '0;
	logic [COUNT_BITS-1:0]     count = '0;
	logic                      out_valid;
	logic                      out_stall = 1'b0;
	logic [DAY_BITS-1:0]       day;
	logic [MONTH_BITS-1:0]     month;
	logic [OUT_YEAR_BITS-1:0]  year;
	logic                      year_overflow;

	// Predicted calendar state, kept in plain integers.
	int unsigned cal_day = 1;
	int unsigned cal_month = 0;
	int unsigned cal_year = 0;

	date_result_t expected_dates [$];
	date_result_t got_date;
	date_result_t want_date;

	int sender_idle_pct = 0;
	int recv_stall_pct = 0;
	int err_count = 0;
	int n_sent = 0;
	int n_load = 0;
	int n_add_days = 0;
	int n_add_months = 0;
	int n_unused = 0;
	int n_checked = 0;
	int n_overflow = 0;
	int cycle_count = 0;

	calendar_date_advance dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.command(command),
		.load_day(load_day),
		.load_month(load_month),
		.load_year(load_year),
		.count(count),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.day(day),
		.month(month),
		.year(year),
		.year_overflow(year_overflow)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// Hang guard.
	initial begin : watchdog
		repeat (LIMIT_CYCLES) @(posedge clk);
		$display("%0t: run did not finish within %0d cycles", $realtime, LIMIT_CYCLES);
		$display("[calendar_date_advance] ERROR");
		$finish;
	end

	always @(posedge clk) cycle_count <= cycle_count + 1;

	// Receiver back-pressure, redrawn every cycle.
	always @(posedge clk) out_stall <= ($urandom_range(99) < recv_stall_pct);

	// Gregorian leap rule.
	function automatic bit is_leap(input int unsigned y);
		return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
	endfunction

	function automatic int unsigned days_in_month(input int unsigned m, input int unsigned y);
		int unsigned idx;
		idx = m % MONTHS_PER_YEAR;
		if (idx == FEBRUARY && is_leap(y))
			return 29;
		return MONTH_DAYS[idx];
	endfunction

	// Apply one request to the predicted calendar and queue the date it should return.
	task automatic advance_calendar(input logic [1:0] cmd, input logic [DAY_BITS-1:0] ld_day,
			input logic [MONTH_BITS-1:0] ld_month, input logic [LOAD_YEAR_BITS-1:0] ld_year,
			input logic [COUNT_BITS-1:0] cnt);
		int unsigned sum;
		int unsigned len;
		int unsigned d;
		bit ovf;
		date_result_t r;
		ovf = 1'b0;
		case (cmd)
			CMD_LOAD: begin
				cal_month = ld_month % MONTHS_PER_YEAR;
				cal_year = ld_year & YEAR_MAX;
				len = days_in_month(cal_month, cal_year);
				d = ld_day;
				if (d == 0)
					d = 1;
				if (d > len)
					d = len;
				cal_day = d;
				n_load++;
			end
			CMD_ADD_DAYS: begin
				// Walk month by month; the year holds at its maximum and flags overflow.
				sum = cal_day + cnt;
				len = days_in_month(cal_month, cal_year);
				while (sum > len) begin
					sum -= len;
					if (cal_month == DECEMBER) begin
						cal_month = 0;
						if (cal_year >= YEAR_MAX) begin
							cal_year = YEAR_MAX;
							ovf = 1'b1;
						end else begin
							cal_year++;
						end
					end else begin
						cal_month++;
					end
					len = days_in_month(cal_month, cal_year);
				end
				cal_day = sum;
				n_add_days++;
			end
			CMD_ADD_MONTHS: begin
				cal_month = (cal_month + cnt) % MONTHS_PER_YEAR;
				n_add_months++;
			end
			default: begin
				n_unused++;
			end
		endcase
		r.day = DAY_BITS'(cal_day);
		r.month = MONTH_BITS'(cal_month);
		r.year = OUT_YEAR_BITS'(cal_year);
		r.ovf = ovf;
		expected_dates.push_back(r);
	endtask

	// Send one request, with random idle cycles ahead of it, and predict its result.
	task automatic send_request(input logic [1:0] cmd, input logic [DAY_BITS-1:0] d,
			input logic [MONTH_BITS-1:0] m, input logic [LOAD_YEAR_BITS-1:0] y,
			input logic [COUNT_BITS-1:0] c);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		load_day <= d;
		load_month <= m;
		load_year <= y;
		count <= c;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		advance_calendar(cmd, d, m, y, c);
		n_sent++;
	endtask

	// Hold the sender off until every outstanding result has been returned.
	task automatic pause_until_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_dates.size() != 0)
			@(posedge clk);
	endtask

	// Compare each returned date with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			got_date = '{day, month, year, year_overflow};
			if (expected_dates.size() == 0) begin
				err_count++;
				$display("%0t: unexpected result, expected none, actual %0d/%0d/%0d ovf %0b",
					$realtime, got_date.day, got_date.month, got_date.year, got_date.ovf);
			end else begin
				want_date = expected_dates.pop_front();
				if (got_date !== want_date) begin
					err_count++;
					$display("%0t: mismatch, expected %0d/%0d/%0d ovf %0b, actual %0d/%0d/%0d ovf %0b",
						$realtime, want_date.day, want_date.month, want_date.year,
						want_date.ovf, got_date.day, got_date.month, got_date.year,
						got_date.ovf);
				end
				n_checked++;
				if (got_date.ovf)
					n_overflow++;
			end
		end
	end

	// Load clamping: day zero, day past month end, month codes above December.
	task automatic test_load_limits();
		send_request(CMD_LOAD, 5'd0, 4'd0, 16'd2023, 16'd0);
		send_request(CMD_LOAD, 5'd31, 4'd3, 16'd2023, 16'hFFFF);
		send_request(CMD_LOAD, 5'd31, 4'd15, 16'hFFFF, 16'd0);
		send_request(CMD_LOAD, 5'd31, 4'd12, 16'd0, 16'd0);
	endtask

	// February 29 in years divisible by 400, by 100 but not 400, and by 4 only.
	task automatic test_leap_rules();
		send_request(CMD_LOAD, 5'd29, FEBRUARY, 16'd2000, 16'd0);
		send_request(CMD_LOAD, 5'd29, FEBRUARY, 16'd1900, 16'd0);
		send_request(CMD_LOAD, 5'd29, FEBRUARY, 16'd2024, 16'd0);
		send_request(CMD_LOAD, 5'd29, FEBRUARY, 16'd0, 16'd0);
		send_request(CMD_ADD_DAYS, 5'd0, 4'd0, 16'd0, 16'd1);
		send_request(CMD_LOAD, 5'd28, FEBRUARY, 16'd2100, 16'd0);
		send_request(CMD_ADD_DAYS, 5'd0, 4'd0, 16'd0, 16'd1);
	endtask

	// Month walking, including a day left past month end by add-months.
	task automatic test_month_walk();
		send_request(CMD_LOAD, 5'd31, 4'd0, 16'd2023, 16'd0);
		send_request(CMD_ADD_MONTHS, 5'd0, 4'd0, 16'd0, 16'd1);
		send_request(CMD_ADD_DAYS, 5'd0, 4'd0, 16'd0, 16'd0);
		send_request(CMD_ADD_MONTHS, 5'd31, 4'd15, 16'hFFFF, 16'hFFFF);
		send_request(CMD_ADD_DAYS, 5'd31, 4'd15, 16'hFFFF, 16'hFFFF);
		send_request(CMD_ADD_DAYS, 5'd0, 4'd0, 16'd0, 16'd0);
		send_request(CMD_LOAD, 5'd31, DECEMBER, 16'd1999, 16'd0);
		send_request(CMD_ADD_DAYS, 5'd0, 4'd0, 16'd0, 16'd1);
	endtask

	// The spare command code must leave the date alone.
	task automatic test_unused_command();
		send_request(CMD_UNUSED, 5'd31, 4'd15, 16'hFFFF, 16'hFFFF);
		send_request(CMD_UNUSED, 5'd0, 4'd0, 16'd0, 16'd0);
	endtask

	// Year saturation at the top of the range.
	task automatic test_year_saturation();
		send_request(CMD_LOAD, 5'd31, DECEMBER, 16'hFFFF, 16'd0);
		send_request(CMD_ADD_DAYS, 5'd0, 4'd0, 16'd0, 16'd1);
		send_request(CMD_ADD_DAYS, 5'd0, 4'd0, 16'd0, 16'd400);
		send_request(CMD_LOAD, 5'd1, 4'd0, 16'hFFFE, 16'd0);
		send_request(CMD_ADD_DAYS, 5'd0, 4'd0, 16'd0, 16'd800);
	endtask

	// Mostly a load followed by a few adds, with some fully random requests mixed in.
	task automatic test_random_traffic(input int n_items, input int s_pct, input int r_pct);
		int start;
		int n_ops;
		int pick;
		bit paused;
		logic [1:0] cmd;
		logic [LOAD_YEAR_BITS-1:0] y;
		logic [COUNT_BITS-1:0] c;
		sender_idle_pct = s_pct;
		recv_stall_pct = r_pct;
		start = n_sent;
		paused = 1'b0;
		while (n_sent - start < n_items) begin
			if (!paused && n_sent - start >= n_items / 2) begin
				pause_until_drained();
				paused = 1'b1;
			end
			if ($urandom_range(99) < 12) begin
				cmd = 2'($urandom_range(3));
				c = (cmd == CMD_ADD_DAYS) ? COUNT_BITS'($urandom_range(4095))
					: COUNT_BITS'($urandom);
				send_request(cmd, DAY_BITS'($urandom), MONTH_BITS'($urandom),
					LOAD_YEAR_BITS'($urandom), c);
			end else begin
				// Years near the top, on century boundaries, or anywhere.
				pick = $urandom_range(99);
				if (pick < 15)
					y = YEAR_MAX - LOAD_YEAR_BITS'($urandom_range(1));
				else if (pick < 35)
					y = LOAD_YEAR_BITS'($urandom_range(163) * 400 + $urandom_range(3) * 100);
				else
					y = LOAD_YEAR_BITS'($urandom);
				send_request(CMD_LOAD, DAY_BITS'($urandom_range(31, 1)),
					MONTH_BITS'($urandom_range(11)), y, COUNT_BITS'($urandom));
				n_ops = $urandom_range(5, 1);
				repeat (n_ops) begin
					pick = $urandom_range(99);
					if ($urandom_range(99) < 60) begin
						if (pick < 3)
							c = COUNT_BITS'($urandom);
						else if (pick < 30)
							c = COUNT_BITS'($urandom_range(2000));
						else
							c = COUNT_BITS'($urandom_range(62));
						send_request(CMD_ADD_DAYS, DAY_BITS'($urandom), MONTH_BITS'($urandom),
							LOAD_YEAR_BITS'($urandom), c);
					end else begin
						c = (pick < 50) ? COUNT_BITS'($urandom) : COUNT_BITS'($urandom_range(24));
						send_request(CMD_ADD_MONTHS, DAY_BITS'($urandom), MONTH_BITS'($urandom),
							LOAD_YEAR_BITS'($urandom), c);
					end
				end
			end
		end
	endtask

	// Test sequence.
	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_load_limits();
		test_leap_rules();
		test_month_walk();
		test_unused_command();
		test_year_saturation();
		pause_until_drained();

		test_random_traffic(61, 0, 0);
		test_random_traffic(61, 47, 0);
		test_random_traffic(61, 0, 47);
		test_random_traffic(61, 14, 14);

		// Drain, then give the block time to emit anything it should not.
		pause_until_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d requests: %0d loads, %0d day adds, %0d month adds, %0d unused.",
			n_sent, n_load, n_add_days, n_add_months, n_unused);
		$display("Checked %0d dates, %0d with year overflow, in %0d cycles, %0d errors.",
			n_checked, n_overflow, cycle_count, err_count);
		if (err_count == 0)
			$display("[calendar_date_advance] OK");
		else
			$display("[calendar_date_advance] ERROR");
		$finish;
	end

endmodule
